/* rtl/core/sic_pkg.sv */
// Shared types and constants of the string inversion counter.
`default_nettype none
package sic_pkg;

	localparam int unsigned CNT_W = 11;
	localparam logic [CNT_W-1:0] COUNT_MAX = 11'h7FF;
	localparam int unsigned IN_SYM_W = 8;

	typedef struct packed {
		logic start;
		logic scan;
		logic store;
		logic mark_ovf;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic scan_done;
		logic last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/core/sic_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sic_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sic_datapath.sv */
// Datapath: symbol store, scan counter, running total and output register.
`default_nettype none
module sic_datapath #(
	parameter int unsigned MAX_LEN     = 64,
	parameter int unsigned SYMBOL_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sic_pkg::cmd_t                 cmd,
	output sic_pkg::sts_t                      sts,
	input  wire logic [sic_pkg::IN_SYM_W-1:0]  symbol,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [sic_pkg::CNT_W-1:0]     inversion_count,
	output logic                               too_long
);

	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned FW = $clog2(MAX_LEN + 1);
	localparam int unsigned XW = (SYMBOL_BITS > sic_pkg::IN_SYM_W) ?
		SYMBOL_BITS : sic_pkg::IN_SYM_W;
	localparam logic [FW-1:0] FILL_MAX = FW'(MAX_LEN);

	logic [XW-1:0]          sym_x;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic                   last_q;
	logic [FW-1:0]          fill_q;
	logic [FW-1:0]          idx_q;
	logic                   pend_q;
	logic [sic_pkg::CNT_W-1:0] total_q;
	logic                   ovf_q;
	logic                   issue;
	logic [SYMBOL_BITS-1:0] rdata;

	assign sym_x = XW'(symbol);
	assign issue = cmd.scan && (idx_q != fill_q);

	sic_ram #(
		.WIDTH(SYMBOL_BITS),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(fill_q[AW-1:0]),
		.wdata(sym_q),
		.re   (issue),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sym_q  <= sym_x[SYMBOL_BITS-1:0];
			last_q <= last;
		end
		if (cmd.emit) begin
			inversion_count <= total_q;
			too_long        <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			total_q   <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			pend_q <= issue;
			if (pend_q && (rdata > sym_q) && (total_q != sic_pkg::COUNT_MAX)) begin
				total_q <= total_q + 1'b1;
			end
			if (cmd.store) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.mark_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.emit) begin
				fill_q    <= '0;
				total_q   <= '0;
				ovf_q     <= 1'b0;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.full      = (fill_q == FILL_MAX);
	assign sts.scan_done = (idx_q == fill_q) && !pend_q;
	assign sts.last      = last_q;
	assign sts.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

/* rtl/core/sic_ctrl.sv */
// Controller state machine that sequences accept, scan, store and emit.
`default_nettype none
module sic_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire sic_pkg::sts_t sts,
	output sic_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FULL_NEXT,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.start    = accept;
		cmd.mark_ovf = accept && sts.full;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.store    = (state_q == ST_SCAN) && sts.scan_done;
		cmd.emit     = (state_q == ST_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= sts.full ? ST_FULL_NEXT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= sts.last ? ST_EMIT : ST_IDLE;
					end
				end
				ST_FULL_NEXT: begin
					state_q <= sts.last ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/string_inversion_counter_top.sv */
// Top level of the string inversion counter.
// An item is accepted in the idle state, then the store is read once per symbol held; when
// the last read data has been compared, the symbol is written to the store.
// An item that arrives with the store full is not stored and marks the string as too long.
// The item marked last then moves the total to the output register, which waits while the output is held.
// Reset clears the running count, the fill level and the overflow flag.
`default_nettype none
module string_inversion_counter_top #(
	parameter int unsigned MAX_LEN     = 64,
	parameter int unsigned SYMBOL_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [sic_pkg::IN_SYM_W-1:0]  symbol,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [sic_pkg::CNT_W-1:0]     inversion_count,
	output logic                               too_long
);

	sic_pkg::cmd_t cmd;
	sic_pkg::sts_t sts;

	sic_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sic_datapath #(
		.MAX_LEN    (MAX_LEN),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.symbol         (symbol),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.inversion_count(inversion_count),
		.too_long       (too_long)
	);

endmodule
`default_nettype wire

/* sim/tb_string_inversion_counter_top.sv */
`timescale 1ns / 1ps
// Testbench of the string inversion counter: random strings, a model of the count, result checks.
module tb_string_inversion_counter_top;

	localparam int unsigned MAX_LEN  = 64;
	localparam int unsigned SYM_BITS = 8;
	localparam int unsigned ITEM_GOAL = 1150;
	localparam int unsigned CNT_W    = sic_pkg::CNT_W;
	localparam int unsigned IN_SYM_W = sic_pkg::IN_SYM_W;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             too_long;
	} string_result_t;

	class inversion_scoreboard;
		logic [SYM_BITS-1:0] held [MAX_LEN];
		int unsigned         fill;
		logic [CNT_W-1:0]    total;
		bit                  overflow;
		string_result_t      pending_results [$];
		int unsigned         errors;

		function new();
			errors = 0;
			clear_string();
		endfunction

		function void clear_string();
			fill = 0;
			total = '0;
			overflow = 0;
		endfunction

		function void note_symbol(input logic [IN_SYM_W-1:0] sym_in, input logic last_in);
			logic [SYM_BITS-1:0] sym;
			int unsigned         greater;
			logic [CNT_W:0]      sum;
			string_result_t      res;
			sym = sym_in[SYM_BITS-1:0];
			greater = 0;
			if (fill < MAX_LEN) begin
				for (int k = 0; k < fill; k++)
					if (held[k] > sym)
						greater++;
				sum = {1'b0, total} + greater[CNT_W:0];
				total = (sum > {1'b0, sic_pkg::COUNT_MAX}) ?
					sic_pkg::COUNT_MAX : sum[CNT_W-1:0];
				held[fill] = sym;
				fill++;
			end else begin
				overflow = 1;
			end
			if (last_in) begin
				res.count = total;
				res.too_long = overflow;
				pending_results.push_back(res);
				clear_string();
			end
		endfunction

		function void check_result(input logic [CNT_W-1:0] count_in, input logic too_long_in);
			string_result_t exp;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, inversion_count %0d too_long %0d",
					$time, count_in, too_long_in);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			if (count_in !== exp.count) begin
				$display("%0t: inversion_count expected %0d actual %0d",
					$time, exp.count, count_in);
				errors++;
			end
			if (too_long_in !== exp.too_long) begin
				$display("%0t: too_long expected %0d actual %0d",
					$time, exp.too_long, too_long_in);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [IN_SYM_W-1:0]   symbol = '0;
	logic                  last = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CNT_W-1:0]      inversion_count;
	logic                  too_long;
	logic                  steady = 1'b0;
	int unsigned           items_sent = 0;

	inversion_scoreboard sb = new();

	string_inversion_counter_top #(
		.MAX_LEN    (MAX_LEN),
		.SYMBOL_BITS(SYM_BITS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.symbol         (symbol),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.inversion_count(inversion_count),
		.too_long       (too_long)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("[string_inversion_counter_top] ERROR");
		$finish;
	end

	task automatic send_item(input logic [IN_SYM_W-1:0] sym, input logic lst);
		while (!steady && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= sym;
		last <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_symbol(sym, lst);
		items_sent++;
	endtask

	function automatic logic [IN_SYM_W-1:0] pick_symbol(input int unsigned alphabet);
		int unsigned r;
		r = $urandom_range(0, 9);
		case (alphabet)
			0: pick_symbol = IN_SYM_W'($urandom_range(0, 255));
			1: pick_symbol = IN_SYM_W'($urandom_range(0, 3));
			default: begin
				if (r < 4)
					pick_symbol = '0;
				else if (r < 8)
					pick_symbol = '1;
				else
					pick_symbol = IN_SYM_W'($urandom_range(0, 255));
			end
		endcase
	endfunction

	task automatic send_string(input int unsigned len);
		int unsigned alphabet;
		alphabet = $urandom_range(0, 2);
		for (int i = 0; i < len; i++)
			send_item(pick_symbol(alphabet), (i == len - 1));
	endtask

	task automatic send_ramp(input int unsigned len, input bit down);
		for (int i = 0; i < len; i++)
			send_item(down ? IN_SYM_W'(255 - i) : IN_SYM_W'(i), (i == len - 1));
	endtask

	initial begin
		int unsigned r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h07, 1'b0);
		send_item(8'h07, 1'b0);
		send_item(8'h07, 1'b1);
		send_item(8'h03, 1'b0);
		send_item(8'h02, 1'b0);
		send_item(8'h01, 1'b1);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b1);
		send_item(8'h55, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b1);

		// Full store both ways, then overruns by one and by several, each before a short string.
		send_ramp(MAX_LEN, 1'b1);
		send_ramp(MAX_LEN, 1'b0);
		send_ramp(MAX_LEN + 1, 1'b1);
		send_item(8'h10, 1'b0);
		send_item(8'h01, 1'b1);
		send_ramp(MAX_LEN + 6, 1'b1);
		send_item(8'hFE, 1'b1);

		while (items_sent < ITEM_GOAL) begin
			steady <= (items_sent >= 600 && items_sent < 800);
			r = $urandom_range(0, 99);
			if (r < 70)
				send_string($urandom_range(1, 8));
			else if (r < 97)
				send_string($urandom_range(9, 30));
			else
				send_string($urandom_range(MAX_LEN - 4, MAX_LEN + 8));
		end
		steady <= 1'b0;
		in_valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("[string_inversion_counter_top] OK");
		end else begin
			$display("%0t: %0d results still expected", $time, sb.pending_results.size());
			$display("[string_inversion_counter_top] ERROR");
		end
		$finish;
	end

	initial begin
		int unsigned cyc;
		int unsigned hold_left;
		cyc = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(inversion_count, too_long);
			cyc++;
			if (cyc == 30 || cyc == 25000)
				hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 23);
			end
		end
	end

endmodule
